// ===== rtl/core/bhpq_pkg.sv =====
`default_nettype none

package bhpq_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int TAG_W  = 16;
  localparam int PRI_W  = 8;
  localparam int COST_W = 16;
  localparam int CAP_W  = 7;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRI_W-1:0]  pri;
    logic [COST_W-1:0] cst;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_DONE,
    ST_FULL,
    ST_EMPTY
  } status_t;

  typedef struct packed {
    status_t          status;
    entry_t           head;
    logic [CNT_W-1:0] count;
  } res_t;

  function automatic logic ranks_ahead(input entry_t a, input entry_t b);
    logic r;
    if (a.pri != b.pri) begin
      r = (a.pri > b.pri);
    end else begin
      r = (a.cst < b.cst);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bhpq_ram.sv =====
`default_nettype none

module bhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/bhpq_ctrl.sv =====
`default_nettype none

module bhpq_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        req_type,
  input  wire bhpq_pkg::entry_t            in_entry,
  input  wire logic [bhpq_pkg::CNT_W-1:0]  cap_eff,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output bhpq_pkg::res_t                   res
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_DN_DEC,
    S_HEAD,
    S_HEAD_WAIT,
    S_FINISH
  } state_t;

  state_t                        state;
  bhpq_pkg::entry_t              mov;
  bhpq_pkg::entry_t              best;
  logic                          best_moved;
  logic [bhpq_pkg::IDX_W-1:0]    idx;
  logic [bhpq_pkg::IDX_W-1:0]    best_idx;
  logic [bhpq_pkg::CNT_W-1:0]    cnt;
  bhpq_pkg::status_t             status;
  bhpq_pkg::entry_t              head;

  logic                          we;
  logic [bhpq_pkg::IDX_W-1:0]    waddr;
  logic [bhpq_pkg::IDX_W-1:0]    raddr;
  bhpq_pkg::entry_t              wdata;
  logic [bhpq_pkg::ENTRY_W-1:0]  rdata_raw;
  bhpq_pkg::entry_t              rdata;

  logic [bhpq_pkg::IDX_W-1:0]    parent;
  logic [bhpq_pkg::CNT_W-1:0]    left;
  logic [bhpq_pkg::CNT_W:0]      right;
  logic                          left_in;
  logic                          right_in;
  logic                          in_xfer;

  assign rdata    = bhpq_pkg::entry_t'(rdata_raw);
  assign parent   = (idx - bhpq_pkg::IDX_W'(1)) >> 1;
  assign left     = {idx, 1'b1};
  assign right    = (bhpq_pkg::CNT_W+1)'({idx, 1'b0}) + (bhpq_pkg::CNT_W+1)'(2);
  assign left_in  = (left < cnt);
  assign right_in = (right < {1'b0, cnt});
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  bhpq_ram #(
    .WIDTH(bhpq_pkg::ENTRY_W),
    .DEPTH(bhpq_pkg::DEPTH)
  ) u_heap (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = mov;
    raddr = '0;
    unique case (state)
      S_IDLE: begin
        raddr = bhpq_pkg::IDX_W'(cnt - bhpq_pkg::CNT_W'(1));
      end
      S_UP_CHK: begin
        raddr = parent;
        we    = (idx == '0);
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (bhpq_pkg::ranks_ahead(mov, rdata)) begin
          wdata = rdata;
        end
      end
      S_DN_L: begin
        raddr = left[bhpq_pkg::IDX_W-1:0];
        we    = !left_in;
      end
      S_DN_R: begin
        raddr = right[bhpq_pkg::IDX_W-1:0];
      end
      S_DN_DEC: begin
        we = 1'b1;
        if (best_moved) begin
          wdata = best;
        end
      end
      S_DN_LOAD, S_DN_CMP, S_HEAD, S_HEAD_WAIT, S_FINISH: begin
        raddr = '0;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            status <= bhpq_pkg::ST_DONE;
            mov    <= in_entry;
            if (req_type == bhpq_pkg::REQ_INSERT) begin
              if (cnt >= cap_eff) begin
                status <= bhpq_pkg::ST_FULL;
                state  <= S_HEAD;
              end else begin
                idx   <= cnt[bhpq_pkg::IDX_W-1:0];
                cnt   <= cnt + bhpq_pkg::CNT_W'(1);
                state <= S_UP_CHK;
              end
            end else begin
              if (cnt == '0) begin
                status <= bhpq_pkg::ST_EMPTY;
                state  <= S_HEAD;
              end else begin
                cnt <= cnt - bhpq_pkg::CNT_W'(1);
                idx <= '0;
                if (cnt == bhpq_pkg::CNT_W'(1)) begin
                  state <= S_HEAD;
                end else begin
                  state <= S_DN_LOAD;
                end
              end
            end
          end
        end
        S_UP_CHK: begin
          if (idx == '0) begin
            state <= S_HEAD;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (bhpq_pkg::ranks_ahead(mov, rdata)) begin
            idx   <= parent;
            state <= S_UP_CHK;
          end else begin
            state <= S_HEAD;
          end
        end
        S_DN_LOAD: begin
          mov   <= rdata;
          state <= S_DN_L;
        end
        S_DN_L: begin
          if (left_in) begin
            state <= S_DN_R;
          end else begin
            state <= S_HEAD;
          end
        end
        S_DN_R: begin
          best_idx <= left[bhpq_pkg::IDX_W-1:0];
          if (bhpq_pkg::ranks_ahead(rdata, mov)) begin
            best       <= rdata;
            best_moved <= 1'b1;
          end else begin
            best       <= mov;
            best_moved <= 1'b0;
          end
          if (right_in) begin
            state <= S_DN_CMP;
          end else begin
            state <= S_DN_DEC;
          end
        end
        S_DN_CMP: begin
          if (bhpq_pkg::ranks_ahead(rdata, best)) begin
            best       <= rdata;
            best_moved <= 1'b1;
            best_idx   <= right[bhpq_pkg::IDX_W-1:0];
          end
          state <= S_DN_DEC;
        end
        S_DN_DEC: begin
          if (best_moved) begin
            idx   <= best_idx;
            state <= S_DN_L;
          end else begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (cnt == '0) begin
            head  <= '0;
            state <= S_FINISH;
          end else begin
            state <= S_HEAD_WAIT;
          end
        end
        S_HEAD_WAIT: begin
          head  <= rdata;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid  = (state == S_FINISH);
  assign res.status = status;
  assign res.head   = head;
  assign res.count  = cnt;

endmodule

`default_nettype wire

// ===== rtl/core/binary_heap_priority_queue.sv =====
// bounded binary max-heap priority queue of up to 64 entries
// input channel: in_valid / in_stall with req_type, tag, priority_req, cost;
//   req_type 0 inserts the entry, 1 removes the head entry
// output channel: out_valid / out_stall with one result per input transfer:
//   status, head entry, count, empty_res and full_res after the request
// config: cfg_wr_en / cfg_wr_data write the capacity register (reset 64,
//   values above 64 act as 64); write only while the queue is idle
// one request at a time; the heap lives in a single memory with one
//   write and one registered read port, so each sift level costs reads
//   and compares plus a write
// insert: the new entry climbs from the tail towards the root, a level
//   per parent compare; the result follows once the climb stops
// remove: the tail entry moves to the root and descends level by level;
//   a rejected request or a remove of the last entry skips the sift
// the next transfer can be taken in the cycle after the result is handed on
// a finished result sits in the output register; the next request is taken
//   while it waits, but cannot finish until the output stage is free
// when the receiver stalls, the output payload holds steady
// reset empties the queue and restores capacity to 64; no clearing pass
`default_nettype none

module binary_heap_priority_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [15:0] tag,
  input  wire logic [7:0]  priority_req,
  input  wire logic [15:0] cost,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [15:0]      head_tag,
  output logic [7:0]       head_priority,
  output logic [15:0]      head_cost,
  output logic [6:0]       count,
  output logic             empty_res,
  output logic             full_res,
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data
);

  logic [bhpq_pkg::CAP_W-1:0] capacity;
  logic [bhpq_pkg::CNT_W-1:0] cap_eff;
  bhpq_pkg::entry_t           in_entry;
  bhpq_pkg::res_t             res;
  logic                       res_valid;
  logic                       res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bhpq_pkg::CAP_W'(bhpq_pkg::DEPTH);
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // saturate capacity at the heap depth
  assign cap_eff = (capacity > bhpq_pkg::CAP_W'(bhpq_pkg::DEPTH))
                 ? bhpq_pkg::CNT_W'(bhpq_pkg::DEPTH)
                 : bhpq_pkg::CNT_W'(capacity);

  assign in_entry.tag = tag;
  assign in_entry.pri = priority_req;
  assign in_entry.cst = cost;

  bhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .in_entry (in_entry),
    .cap_eff  (cap_eff),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output register
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid     <= 1'b1;
        status        <= 2'(res.status);
        head_tag      <= res.head.tag;
        head_priority <= res.head.pri;
        head_cost     <= res.head.cst;
        count         <= 7'(res.count);
        empty_res     <= (res.count == '0);
        full_res      <= (res.count >= cap_eff);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bhpq_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    status_t     status;
    entry_t      head;
    logic [6:0]  count;
    logic        empty;
    logic        full;
  } heap_outcome_t;

  class heap_scoreboard;
    entry_t slots[DEPTH];
    int held;
    int cap_reg;
    int failures;
    heap_outcome_t outcomes[$];

    function new();
      held = 0;
      cap_reg = 64;
      failures = 0;
    endfunction

    function void set_capacity(logic [6:0] v);
      cap_reg = int'(v);
    endfunction

    function int outstanding();
      return outcomes.size();
    endfunction

    function bit goes_first(entry_t a, entry_t b);
      return (a.pri > b.pri) || ((a.pri == b.pri) && (a.cst < b.cst));
    endfunction

    function void exchange(int i, int j);
      entry_t t;
      t = slots[i];
      slots[i] = slots[j];
      slots[j] = t;
    endfunction

    // model one accepted request and queue the outcome it should produce
    function void note_request(logic req, entry_t e);
      heap_outcome_t o;
      int lim;
      int i;
      int p;
      int l;
      int r;
      int best;
      lim = (cap_reg > DEPTH) ? DEPTH : cap_reg;
      o = '0;
      o.status = ST_DONE;
      if (req == REQ_INSERT) begin
        if (held >= lim) begin
          o.status = ST_FULL;
        end else begin
          slots[held] = e;
          i = held;
          held++;
          while (i > 0) begin
            p = (i - 1) / 2;
            if (!goes_first(slots[i], slots[p])) break;
            exchange(i, p);
            i = p;
          end
        end
      end else if (held == 0) begin
        o.status = ST_EMPTY;
      end else begin
        held--;
        slots[0] = slots[held];
        i = 0;
        while (i < held) begin
          l = 2 * i + 1;
          r = l + 1;
          best = i;
          if (l < held && goes_first(slots[l], slots[best])) best = l;
          if (r < held && goes_first(slots[r], slots[best])) best = r;
          if (best == i) break;
          exchange(i, best);
          i = best;
        end
      end
      o.head = (held > 0) ? slots[0] : '0;
      o.count = 7'(held);
      o.empty = (held == 0);
      o.full = (held >= lim);
      outcomes.push_back(o);
    endfunction

    function void check_result(logic [1:0] st, logic [15:0] htag, logic [7:0] hpri,
                               logic [15:0] hcost, logic [6:0] cnt, logic emp,
                               logic ful);
      heap_outcome_t o;
      if (outcomes.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result transfer with nothing outstanding");
        return;
      end
      o = outcomes.pop_front();
      if (st !== o.status || htag !== o.head.tag || hpri !== o.head.pri ||
          hcost !== o.head.cst || cnt !== o.count || emp !== o.empty ||
          ful !== o.full) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch (exp/act): status %0d/%0d tag %h/%h pri %h/%h cost %h/%h",
                   o.status, st, o.head.tag, htag, o.head.pri, hpri, o.head.cst, hcost);
          $display("  count %0d/%0d empty %b/%b full %b/%b",
                   o.count, cnt, o.empty, emp, o.full, ful);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [15:0] tag;
  logic [7:0]  priority_req;
  logic [15:0] cost;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [15:0] head_tag;
  logic [7:0]  head_priority;
  logic [15:0] head_cost;
  logic [6:0]  count;
  logic        empty_res;
  logic        full_res;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;

  int send_idle;
  int recv_idle;
  int hold_requests;

  heap_scoreboard sb = new();

  binary_heap_priority_queue uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .tag           (tag),
    .priority_req  (priority_req),
    .cost          (cost),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .head_tag      (head_tag),
    .head_priority (head_priority),
    .head_cost     (head_cost),
    .count         (count),
    .empty_res     (empty_res),
    .full_res      (full_res),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver side: random stall, plus long hold-offs on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(status, head_tag, head_priority, head_cost, count,
                      empty_res, full_res);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // entered and left at a rising edge; returns once the transfer has happened
  task automatic send_item(logic r, logic [15:0] t, logic [7:0] p, logic [15:0] c);
    entry_t e;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    req_type = r;
    tag = t;
    priority_req = p;
    cost = c;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    e.tag = t;
    e.pri = p;
    e.cst = c;
    sb.note_request(r, e);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [6:0] v);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(posedge clk);
    sb.set_capacity(v);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int n, int insert_pct);
    logic       r;
    logic [7:0] p;
    logic [15:0] c;
    for (int k = 0; k < n; k++) begin
      r = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
      case ($urandom_range(3))
        0: p = 8'($urandom_range(2));
        1: p = 8'(255 - $urandom_range(2));
        default: p = 8'($urandom_range(255));
      endcase
      // narrow cost range now and then so that ties are common
      c = ($urandom_range(2) == 0) ? 16'($urandom_range(3)) : 16'($urandom_range(65535));
      send_item(r, 16'($urandom_range(65535)), p, c);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_INSERT;
    tag = '0;
    priority_req = '0;
    cost = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    send_idle = 0;
    recv_idle = 0;
    hold_requests = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // directed: extremes, ties, empty and full rejection
    send_item(REQ_REMOVE, 16'h0000, 8'h00, 16'h0000);
    send_item(REQ_INSERT, 16'h0000, 8'h00, 16'h0000);
    send_item(REQ_INSERT, 16'hffff, 8'hff, 16'hffff);
    send_item(REQ_INSERT, 16'h1234, 8'hff, 16'h0000);
    send_item(REQ_INSERT, 16'h4321, 8'hff, 16'h0000);
    send_item(REQ_INSERT, 16'h8000, 8'h80, 16'h8000);
    repeat (5) send_item(REQ_REMOVE, 16'hffff, 8'hff, 16'hffff);
    send_item(REQ_REMOVE, 16'h5555, 8'h55, 16'haaaa);
    send_item(REQ_INSERT, 16'h0a0a, 8'h10, 16'h0001);
    send_item(REQ_INSERT, 16'h0b0b, 8'h20, 16'h0002);
    send_item(REQ_INSERT, 16'h0c0c, 8'h30, 16'h0003);
    wait_idle();
    // capacity below the current count
    write_capacity(7'd2);
    send_item(REQ_INSERT, 16'h0d0d, 8'hff, 16'h0000);
    send_item(REQ_REMOVE, 16'h0000, 8'h00, 16'h0000);
    send_item(REQ_REMOVE, 16'h0000, 8'h00, 16'h0000);
    send_item(REQ_INSERT, 16'h0e0e, 8'h01, 16'hfffe);
    wait_idle();
    write_capacity(7'd0);
    send_item(REQ_INSERT, 16'h0f0f, 8'h7f, 16'h7fff);
    send_item(REQ_REMOVE, 16'h0000, 8'h00, 16'h0000);
    send_item(REQ_REMOVE, 16'h0000, 8'h00, 16'h0000);
    wait_idle();
    write_capacity(7'd1);
    send_item(REQ_INSERT, 16'hbeef, 8'h40, 16'h0100);
    send_item(REQ_INSERT, 16'hcafe, 8'hc0, 16'h0010);
    send_item(REQ_REMOVE, 16'h0000, 8'h00, 16'h0000);
    wait_idle();

    // sender idles lightly, receiver heavily
    send_idle = 37;
    recv_idle = 75;
    write_capacity(7'd64);
    run_random(120, 70);
    run_random(60, 30);
    wait_idle();
    write_capacity(7'd5);
    run_random(60, 50);
    wait_idle();

    // the other way round, with one long hold-off so the queue backs up
    send_idle = 75;
    recv_idle = 37;
    write_capacity(7'd127);
    hold_requests++;
    run_random(110, 85);
    wait_idle();
    write_capacity(7'd1);
    run_random(40, 50);
    wait_idle();

    send_idle = 0;
    recv_idle = 0;
    write_capacity(7'd33);
    run_random(80, 60);
    run_random(80, 35);
    wait_idle();

    if (sb.failures == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
